// ===== hw/rtl/thsw_pkg.sv =====
// package: status codes, register indexes, reset values and lookup tables for the strobe width select
`timescale 1ns / 1ps

package thsw_pkg;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_HOT  = 2'd1,
    ST_WEAK = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_HOT_HEAD_LIMIT        = 2'd0,
    REG_ADAPTER_PRESENT_LEVEL = 2'd1,
    REG_BATTERY_MIN_LEVEL     = 2'd2
  } reg_idx_e;

  localparam int unsigned NumBands  = 14;
  localparam int unsigned NumCols   = 10;
  localparam int unsigned NumVSteps = 8;

  localparam int unsigned BandW  = 4;
  localparam int unsigned ColW   = 4;
  localparam int unsigned WidthW = 11;

  localparam logic [9:0]  HotHeadLimitRst        = 10'd300;
  localparam logic [10:0] AdapterPresentLevelRst = 11'd500;
  localparam logic [10:0] BatteryMinLevelRst     = 11'd830;

  localparam logic [9:0] BandTop = 10'd931;

  localparam logic [0:NumBands-1][9:0] BandFloor = '{
    10'd906, 10'd877, 10'd844, 10'd806, 10'd768, 10'd719, 10'd676,
    10'd626, 10'd577, 10'd530, 10'd480, 10'd434, 10'd384, 10'd341
  };

  localparam logic [0:NumVSteps-1][10:0] VoltFloor = '{
    11'd1010, 11'd990, 11'd960, 11'd930, 11'd910, 11'd890, 11'd860, 11'd840
  };

  localparam logic [0:NumBands-1][0:NumCols-1][WidthW-1:0] WidthTbl = '{
    '{11'd990, 11'd1091, 11'd1148, 11'd1209, 11'd1275,
      11'd1347, 11'd1425, 11'd1510, 11'd1603, 11'd922},
    '{11'd923, 11'd1018, 11'd1071, 11'd1128, 11'd1190,
      11'd1257, 11'd1330, 11'd1409, 11'd1496, 11'd861},
    '{11'd863, 11'd952, 11'd1001, 11'd1054, 11'd1112,
      11'd1175, 11'd1243, 11'd1313, 11'd1399, 11'd805},
    '{11'd803, 11'd885, 11'd931, 11'd981, 11'd1035,
      11'd1093, 11'd1156, 11'd1226, 11'd1301, 11'd749},
    '{11'd749, 11'd826, 11'd869, 11'd915, 11'd966,
      11'd1020, 11'd1079, 11'd1143, 11'd1214, 11'd699},
    '{11'd695, 11'd767, 11'd807, 11'd850, 11'd896,
      11'd947, 11'd1002, 11'd1061, 11'd1127, 11'd648},
    '{11'd648, 11'd714, 11'd752, 11'd792, 11'd835,
      11'd882, 11'd933, 11'd989, 11'd1050, 11'd605},
    '{11'd597, 11'd659, 11'd693, 11'd730, 11'd770,
      11'd813, 11'd860, 11'd912, 11'd968, 11'd557},
    '{11'd553, 11'd610, 11'd642, 11'd676, 11'd713,
      11'd753, 11'd797, 11'd844, 11'd896, 11'd516},
    '{11'd512, 11'd564, 11'd594, 11'd626, 11'd660,
      11'd697, 11'd737, 11'd781, 11'd830, 11'd477},
    '{11'd468, 11'd516, 11'd542, 11'd571, 11'd603,
      11'd637, 11'd674, 11'd714, 11'd758, 11'd436},
    '{11'd430, 11'd474, 11'd498, 11'd525, 11'd554,
      11'd585, 11'd619, 11'd656, 11'd696, 11'd401},
    '{11'd392, 11'd432, 11'd455, 11'd479, 11'd505,
      11'd533, 11'd564, 11'd598, 11'd635, 11'd366},
    '{11'd354, 11'd390, 11'd410, 11'd432, 11'd456,
      11'd482, 11'd510, 11'd540, 11'd573, 11'd330}
  };

endpackage

// ===== hw/rtl/thermal_head_strobe_width_select.sv =====
// top level: thermal print head strobe width select from thermistor, adapter and battery readings
// pipeline: input register, then result register
// throughput: one beat per cycle while the result side is free; both registers then advance together
// reset: valid flags clear, limit registers load 300 / 500 / 830
`timescale 1ns / 1ps

module thermal_head_strobe_width_select (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // thermistor_raw[11:0], adapter_raw[23:12],
                                      // battery_raw[35:24], zero pad[39:36]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // status[1:0], strobe_width_us[12:2], zero pad[15:13]
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i
);

  logic [9:0]  hot_limit_q;
  logic [10:0] adapter_level_q;
  logic [10:0] battery_min_q;

  logic        in_valid_q;
  logic [11:0] therm_q, adapter_q, battery_q;

  logic        out_valid_q;
  logic [1:0]  status_q, status_d;
  logic [10:0] width_q, width_d;

  logic        advance;

  logic [9:0]  therm_s;
  logic [10:0] adapter_s, battery_s;
  logic [3:0]  band;
  logic [3:0]  col;
  logic [3:0]  bat_col;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hot_limit_q     <= thsw_pkg::HotHeadLimitRst;
      adapter_level_q <= thsw_pkg::AdapterPresentLevelRst;
      battery_min_q   <= thsw_pkg::BatteryMinLevelRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        thsw_pkg::REG_HOT_HEAD_LIMIT:        hot_limit_q     <= cfg_data_i[9:0];
        thsw_pkg::REG_ADAPTER_PRESENT_LEVEL: adapter_level_q <= cfg_data_i;
        thsw_pkg::REG_BATTERY_MIN_LEVEL:     battery_min_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      therm_q   <= s_axis_tdata[11:0];
      adapter_q <= s_axis_tdata[23:12];
      battery_q <= s_axis_tdata[35:24];
    end
    if (advance && in_valid_q) begin
      status_q <= status_d;
      width_q  <= width_d;
    end
  end

  assign therm_s   = therm_q[11:2];
  assign adapter_s = adapter_q[11:1];
  assign battery_s = battery_q[11:1];

  // first band whose floor lies below the reading; NumBands if none does or if the reading is above BandTop
  always_comb begin
    band = 4'(thsw_pkg::NumBands);
    for (int b = thsw_pkg::NumBands - 1; b >= 0; b--) begin
      if (therm_s > thsw_pkg::BandFloor[b]) begin
        band = 4'(b);
      end
    end
    if (therm_s > thsw_pkg::BandTop) begin
      band = 4'(thsw_pkg::NumBands);
    end
  end

  always_comb begin
    bat_col = 4'(thsw_pkg::NumVSteps);
    for (int c = thsw_pkg::NumVSteps - 1; c >= 0; c--) begin
      if (battery_s > thsw_pkg::VoltFloor[c]) begin
        bat_col = 4'(c);
      end
    end
  end

  always_comb begin
    status_d = thsw_pkg::ST_HOT;
    width_d  = '0;
    col      = 4'(thsw_pkg::NumCols - 1);
    if (therm_s > hot_limit_q) begin
      if (adapter_s < adapter_level_q && battery_s <= battery_min_q) begin
        status_d = thsw_pkg::ST_WEAK;
      end else begin
        if (adapter_s < adapter_level_q) begin
          col = bat_col;
        end
        if (band < 4'(thsw_pkg::NumBands)) begin
          status_d = thsw_pkg::ST_OK;
          width_d  = thsw_pkg::WidthTbl[band][col];
        end
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, width_q, status_q};

endmodule
